// ===== rtl/mma_pkg.sv =====
// Shared types and constants for the matrix multiply-accumulate block.
package mma_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int POS_W       = 3;

    typedef enum logic [1:0] {
        REQ_LOAD_C = 2'd0,
        REQ_LOAD_A = 2'd1,
        REQ_LOAD_B = 2'd2,
        REQ_RUN    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_INNER_P = 2'd1,
        CFG_COLS_N  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;      // k == 0: start from stored C
        logic             last_k;     // final k: write back and emit
        logic             last_elem;  // final C element of the run
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } mac_tag_t;

endpackage

// ===== rtl/matrix_multiply_accumulate.sv =====
// Matrix multiply-accumulate C += A*B in Q16.16 with one shared MAC unit.
//
// Usage:
// - Command channel: an item transfers at a rising edge with start high and
//   busy low. req_type selects load C, load A, load B or run. Loads write one
//   element at (row, col) in that cycle; a position at or beyond MAX_DIM is dropped.
//   Loads leave busy low, so loads can stream back to back.
// - A run sweeps i, j, k over rows_m x cols_n x inner_p with one 32x32
//   multiplier and one saturating adder, one step per cycle. Each C element
//   is finished after its inner_p steps, written back and emitted at once,
//   so results come out in row-major order.
// - Result channel: strobe marks each result for exactly one cycle; the
//   receiver cannot stall it. last flags the final element of a run.
// - Pipeline: address/memory read, multiply, accumulate. busy stays high
//   until the final result of a run has been emitted.
// - Configuration: wr_en/wr_index/wr_data write rows_m, inner_p, cols_n
//   (0 acts as 1, above MAX_DIM acts as MAX_DIM). Write only while idle.
// - Reset (rst_n low, async) returns to idle with dimensions at 8; the
//   element stores keep no reset value and must be loaded before a run.
module matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic [POS_W-1:0]         row,
    input  logic [POS_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    // result channel
    output logic                     strobe,
    output logic [POS_W-1:0]         out_row,
    output logic [POS_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     last,
    // configuration write port
    input  logic                     wr_en,
    input  logic [1:0]               wr_index,
    input  logic [DIM_W-1:0]         wr_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [IDX_W-1:0] LIM_MAX = IDX_W'(MAX_DIM - 1);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
    localparam int SUM_W  = 49;

    // configuration registers
    logic [DIM_W-1:0] rows_m_reg, inner_p_reg, cols_n_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  m_lim_reg, p_lim_reg, n_lim_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, k_reg;
    logic [IDX_W-1:0]  i_next, j_next, k_next;
    logic              issue;
    logic              issue_end;
    logic              cmd_accept;
    logic              run_accept;
    logic              load_ok;

    // element stores
    logic [DATA_W-1:0] a_mem_reg [DEPTH];
    logic [DATA_W-1:0] b_mem_reg [DEPTH];
    logic [DATA_W-1:0] c_mem_reg [DEPTH];
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] a_addr, b_addr, c_addr, wb_addr;

    // pipeline
    logic                     v1_reg, v2_reg;
    mac_tag_t                 tag0, tag1_reg, tag2_reg;
    logic signed [DATA_W-1:0] a_rd_reg, b_rd_reg, c_rd_reg, c2_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] base;
    logic signed [SUM_W-1:0]  sum_wide;
    logic signed [DATA_W-1:0] sum_sat;
    logic                     wb;

    function automatic logic [IDX_W-1:0] dim_lim(input logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0)
            r = '0;
        else if (d > DIM_MAX)
            r = LIM_MAX;
        else
            r = IDX_W'(d - DIM_W'(1));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    assign cmd_accept = start && !busy;
    assign run_accept = cmd_accept && (req_type == REQ_RUN);
    assign load_ok    = cmd_accept && (req_type != REQ_RUN)
                        && ({1'b0, row} < DIM_MAX) && ({1'b0, col} < DIM_MAX);
    assign load_addr  = {row[IDX_W-1:0], col[IDX_W-1:0]};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIM_W'(8);
            inner_p_reg <= DIM_W'(8);
            cols_n_reg  <= DIM_W'(8);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ROWS_M:  rows_m_reg  <= wr_data;
                CFG_INNER_P: inner_p_reg <= wr_data;
                CFG_COLS_N:  cols_n_reg  <= wr_data;
                default:     ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    assign issue_end = (k_reg == p_lim_reg) && (j_reg == n_lim_reg) && (i_reg == m_lim_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (req_type == REQ_RUN))
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (issue_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        case (state_reg)
            ST_IDLE:  busy  = 1'b0;
            ST_ISSUE: issue = 1'b1;
            ST_DRAIN: ;
            default:  busy  = 1'b1;
        endcase
    end

    // loop counters: k innermost, then j, then i
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (run_accept)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end
        else if (issue)
        begin
            if (k_reg != p_lim_reg)
                k_next = k_reg + IDX_W'(1);
            else
            begin
                k_next = '0;
                if (j_reg != n_lim_reg)
                    j_next = j_reg + IDX_W'(1);
                else
                begin
                    j_next = '0;
                    i_next = i_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            m_lim_reg <= '0;
            p_lim_reg <= '0;
            n_lim_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (run_accept)
            begin
                m_lim_reg <= dim_lim(rows_m_reg);
                p_lim_reg <= dim_lim(inner_p_reg);
                n_lim_reg <= dim_lim(cols_n_reg);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: addresses and tag
    // ---------------------------------------------------------------
    assign a_addr = {i_reg, k_reg};
    assign b_addr = {k_reg, j_reg};
    assign c_addr = {i_reg, j_reg};

    always_comb
    begin
        tag0.first     = (k_reg == '0);
        tag0.last_k    = (k_reg == p_lim_reg);
        tag0.last_elem = (i_reg == m_lim_reg) && (j_reg == n_lim_reg);
        tag0.row       = POS_W'(i_reg);
        tag0.col       = POS_W'(j_reg);
    end

    // ---------------------------------------------------------------
    // Element stores: one write port each, registered read
    // ---------------------------------------------------------------
    assign wb      = v2_reg && tag2_reg.last_k;
    assign wb_addr = {tag2_reg.row[IDX_W-1:0], tag2_reg.col[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (load_ok && (req_type == REQ_LOAD_A))
            a_mem_reg[load_addr] <= value;
        a_rd_reg <= a_mem_reg[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && (req_type == REQ_LOAD_B))
            b_mem_reg[load_addr] <= value;
        b_rd_reg <= b_mem_reg[b_addr];
    end

    // loads only happen while idle, so they never meet a write-back
    always_ff @(posedge clk)
    begin
        if (load_ok && (req_type == REQ_LOAD_C))
            c_mem_reg[load_addr] <= value;
        else if (wb)
            c_mem_reg[wb_addr] <= sum_sat;
        c_rd_reg <= c_mem_reg[c_addr];
    end

    // ---------------------------------------------------------------
    // Stage 2 multiply, stage 3 saturating accumulate
    // ---------------------------------------------------------------
    always_comb
    begin
        base     = tag2_reg.first ? c2_reg : acc_reg;
        // product >>> 16 floors toward minus infinity
        sum_wide = SUM_W'(base) + SUM_W'($signed(prod_reg[63:16]));
        if (sum_wide[SUM_W-1:DATA_W-1] == '0 || sum_wide[SUM_W-1:DATA_W-1] == '1)
            sum_sat = sum_wide[DATA_W-1:0];
        else if (sum_wide[SUM_W-1])
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= tag0;
        tag2_reg <= tag1_reg;
        c2_reg   <= c_rd_reg;
        prod_reg <= a_rd_reg * b_rd_reg;
        if (v2_reg)
            acc_reg <= sum_sat;
        if (wb)
        begin
            out_row   <= tag2_reg.row;
            out_col   <= tag2_reg.col;
            out_value <= sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            strobe <= 1'b0;
            last   <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            strobe <= wb;
            last   <= wb && tag2_reg.last_elem;
        end
    end

`ifndef SYNTHESIS
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe outside a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("block still busy after final result");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_RUN)) |=> busy)
        else $error("run transfer did not start the sequencer");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> busy)
        else $error("MAC pipeline active while idle");
`endif

endmodule
